// File: sv/mma_pkg.sv
// Shared constants, codes and helpers for the metric accumulator.
package mma_pkg;

  localparam int MAX_CLASSES_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int SCORE_WIDTH_DEF = 16;

  localparam int SUM_W   = 48;
  localparam int NUM_W   = 64;
  localparam int DEN_W   = 64;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [2:0] MODE_ACC  = 3'd0;
  localparam logic [2:0] MODE_PREC = 3'd1;
  localparam logic [2:0] MODE_REC  = 3'd2;
  localparam logic [2:0] MODE_F1   = 3'd3;
  localparam logic [2:0] MODE_MSE  = 3'd4;
  localparam logic [2:0] MODE_MAE  = 3'd5;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_CLASS  = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic [SUM_W-1:0] Q16_MAX = SUM_W'(65535);

  // Clamp a Q0.16 ratio at just under one.
  function automatic logic [SUM_W-1:0] sat16(input logic [NUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    if (v > NUM_W'(65535)) r = Q16_MAX;
    else r = SUM_W'(v[15:0]);
    return r;
  endfunction

endpackage

// File: sv/mma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mma_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/mma_div.sv
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
module mma_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] d;
  logic             dz;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem, q[NUM_W-1]};
  assign diff    = shifted - {1'b0, d};
  assign ge      = shifted >= {1'b0, d};
  assign quo     = dz ? '0 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
      d   <= den;
      dz  <= den == '0;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      q   <= {q[NUM_W-2:0], ge};
    end
  end

endmodule

// File: sv/ml_metric_accumulator.sv
// Metric accumulator top level: config port, sequencer and report datapath.
// Accumulate: each transaction passes S_ACC, then S_SQ for a squared error
//   that does not saturate, or S_CELL when it closes a sample.
// Report: one division for accuracy, MSE and MAE; classification walks
//   2n RAM reads per class plus one division each, then one more division.
// After reset the confusion RAM is cleared, all MAX_CLASSES^2 cells, with busy high.
// Results appear on done for one cycle and cannot be held off.
module ml_metric_accumulator #(
  parameter int MAX_CLASSES = mma_pkg::MAX_CLASSES_DEF,
  parameter int COUNT_WIDTH = mma_pkg::COUNT_WIDTH_DEF,
  parameter int SCORE_WIDTH = mma_pkg::SCORE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mma_pkg::PADDR_W-1:0]     paddr,
  input  logic [mma_pkg::PDATA_W-1:0]     pwdata,
  output logic [mma_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic signed [SCORE_WIDTH-1:0]   pred_score,
  input  logic signed [SCORE_WIDTH-1:0]   target_score,
  input  logic                            last_in_sample,
  output logic                            done,
  output logic [mma_pkg::SUM_W-1:0]       metric_value,
  output logic                            no_samples
);
  import mma_pkg::*;

  localparam int CPW   = $clog2(MAX_CLASSES);
  localparam int DEPTH = MAX_CLASSES * MAX_CLASSES;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = ((SCORE_WIDTH > 16) ? SCORE_WIDTH : 16) + 1;
  localparam int TOT_W = 17 + $clog2(MAX_CLASSES + 1);
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_ACC   = 13'b0000000000100,
    S_SQ    = 13'b0000000001000,
    S_CELL  = 13'b0000000010000,
    S_RLOAD = 13'b0000000100000,
    S_RDIV  = 13'b0000001000000,
    S_WALK  = 13'b0000010000000,
    S_WEND  = 13'b0000100000000,
    S_CLOAD = 13'b0001000000000,
    S_CDIV  = 13'b0010000000000,
    S_ALOAD = 13'b0100000000000,
    S_ADIV  = 13'b1000000000000
  } state_t;

  state_t state;

  logic [2:0]               mode;
  logic [4:0]               class_count;
  logic signed [15:0]       threshold;

  logic [SUM_W-1:0]         score_sum;
  logic [COUNT_WIDTH-1:0]   item_count;
  logic [CPW-1:0]           class_position;
  logic signed [SCORE_WIDTH-1:0] best_pred_score;
  logic signed [SCORE_WIDTH-1:0] best_target_score;
  logic [CPW-1:0]           best_pred_class;
  logic [CPW-1:0]           best_target_class;

  logic signed [SCORE_WIDTH-1:0] p_lat;
  logic signed [SCORE_WIDTH-1:0] t_lat;
  logic                     last_lat;
  logic [XW-1:0]            ad_lat;
  logic [SUM_W-1:0]         sq;
  logic [AW-1:0]            cell_addr;
  logic [AW-1:0]            clr_addr;

  logic [CPW-1:0]           wc;
  logic [CPW-1:0]           wi;
  logic                     phase;
  logic                     pend_v;
  logic                     pend_col;
  logic                     pend_diag;
  logic [DEN_W-1:0]         row_sum;
  logic [DEN_W-1:0]         col_sum;
  logic [DEN_W-1:0]         tp;
  logic [TOT_W-1:0]         total;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [COUNT_WIDTH-1:0]   ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [COUNT_WIDTH-1:0]   ram_rdata;

  logic                     div_start;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic                     div_busy;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;

  logic                     accept;
  logic                     cfg_we;
  logic [7:0]               eff_n8;
  logic signed [XW-1:0]     p_x;
  logic signed [XW-1:0]     t_x;
  logic signed [XW-1:0]     d_x;
  logic [XW-1:0]            ad_in;
  logic [NUM_W-1:0]         ad_ext;
  logic                     ad_big;
  logic                     dec_p;
  logic                     dec_t;
  logic [SUM_W-1:0]         add_v;
  logic [SUM_W:0]           sum_raw;
  logic [SUM_W-1:0]         sum_sat;
  logic [COUNT_WIDTH-1:0]   count_inc;
  logic                     pos0;
  logic                     upd_p;
  logic                     upd_t;
  logic [CPW-1:0]           nbpc;
  logic [CPW-1:0]           nbtc;
  logic                     close_sample;
  logic [AW-1:0]            row_addr;
  logic [AW-1:0]            col_addr;
  logic                     count_zero;
  logic                     simple_mode;

  assign pready = 1'b1;
  assign busy   = state != S_IDLE;
  assign accept = start && !busy;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = PDATA_W'(mode);
      REG_CLASS:  prdata = PDATA_W'(class_count);
      REG_THRESH: prdata = PDATA_W'({16'h0, threshold});
      default:    prdata = '0;
    endcase
  end

  // Zero classes acts as one, too many acts as the maximum.
  always_comb begin
    if (class_count == 5'd0) eff_n8 = 8'd1;
    else if (8'(class_count) > 8'(MAX_CLASSES)) eff_n8 = 8'(MAX_CLASSES);
    else eff_n8 = 8'(class_count);
  end

  assign p_x    = XW'(pred_score);
  assign t_x    = XW'(target_score);
  assign d_x    = p_x - t_x;
  assign ad_in  = d_x[XW-1] ? XW'(-d_x) : XW'(d_x);
  assign ad_ext = NUM_W'(ad_lat);
  assign ad_big = |ad_ext[NUM_W-1:24];

  assign dec_p = XW'(p_lat) >= XW'(threshold);
  assign dec_t = XW'(t_lat) >= XW'(threshold);

  always_comb begin
    case (state)
      S_SQ:    add_v = sq;
      default: add_v = (mode == MODE_MAE) ? ad_ext[SUM_W-1:0] : SUM_W'(dec_p == dec_t);
    endcase
  end

  assign sum_raw   = {1'b0, score_sum} + {1'b0, add_v};
  assign sum_sat   = sum_raw[SUM_W] ? {SUM_W{1'b1}} : sum_raw[SUM_W-1:0];
  assign count_inc = (item_count == CMAX) ? item_count : item_count + COUNT_WIDTH'(1);

  assign pos0  = class_position == '0;
  assign upd_p = pos0 || (p_lat > best_pred_score);
  assign upd_t = pos0 || (t_lat > best_target_score);
  assign nbpc  = pos0 ? '0 : (upd_p ? class_position : best_pred_class);
  assign nbtc  = pos0 ? '0 : (upd_t ? class_position : best_target_class);
  assign close_sample = last_lat || ((8'(class_position) + 8'd1) >= eff_n8);

  assign row_addr = AW'(wc) * AW'(MAX_CLASSES) + AW'(wi);
  assign col_addr = AW'(wi) * AW'(MAX_CLASSES) + AW'(wc);

  assign count_zero  = item_count == '0;
  assign simple_mode = (mode == MODE_ACC) || (mode == MODE_MSE) || (mode == MODE_MAE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = (ram_rdata == CMAX) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
    ram_raddr = row_addr;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_ACC:   ram_raddr = AW'(nbtc) * AW'(MAX_CLASSES) + AW'(nbpc);
      S_CELL:  ram_we = 1'b1;
      S_WALK:  ram_raddr = phase ? col_addr : row_addr;
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_RLOAD: begin
        div_start = !count_zero && simple_mode;
        div_num   = (mode == MODE_ACC) ? NUM_W'({score_sum, 16'h0})
                                       : NUM_W'(score_sum);
        div_den   = DEN_W'(item_count);
      end
      S_CLOAD: begin
        div_start = 1'b1;
        div_num   = (mode == MODE_F1) ? NUM_W'({tp, 17'h0}) : NUM_W'({tp, 16'h0});
        case (mode)
          MODE_PREC: div_den = col_sum;
          MODE_REC:  div_den = row_sum;
          default:   div_den = row_sum + col_sum;
        endcase
      end
      S_ALOAD: begin
        div_start = 1'b1;
        div_num   = NUM_W'(total);
        div_den   = DEN_W'(eff_n8);
      end
      default: div_start = 1'b0;
    endcase
  end

  mma_ram #(
    .W     (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mma_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Control, configuration and accumulator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      clr_addr          <= '0;
      mode              <= MODE_ACC;
      class_count       <= 5'd2;
      threshold         <= 16'sd2048;
      score_sum         <= '0;
      item_count        <= '0;
      class_position    <= '0;
      best_pred_score   <= '0;
      best_pred_class   <= '0;
      best_target_score <= '0;
      best_target_class <= '0;
      done              <= 1'b0;
      pend_v            <= 1'b0;
    end else begin
      done   <= 1'b0;
      pend_v <= state == S_WALK;
      if (cfg_we) begin
        case (paddr[3:2])
          REG_MODE:   mode <= pwdata[2:0];
          REG_CLASS:  class_count <= pwdata[4:0];
          REG_THRESH: threshold <= pwdata[15:0];
          default:    mode <= mode;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) state <= command ? S_RLOAD : S_ACC;
        end
        S_ACC: begin
          state <= S_IDLE;
          case (mode)
            MODE_ACC, MODE_MAE: begin
              score_sum  <= sum_sat;
              item_count <= count_inc;
            end
            MODE_MSE: begin
              if (ad_big) begin
                score_sum  <= {SUM_W{1'b1}};
                item_count <= count_inc;
              end else begin
                state <= S_SQ;
              end
            end
            MODE_PREC, MODE_REC, MODE_F1: begin
              if (upd_p) best_pred_score <= p_lat;
              if (upd_t) best_target_score <= t_lat;
              best_pred_class   <= nbpc;
              best_target_class <= nbtc;
              if (close_sample) begin
                class_position <= '0;
                item_count     <= count_inc;
                state          <= S_CELL;
              end else begin
                class_position <= class_position + CPW'(1);
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_SQ: begin
          score_sum  <= sum_sat;
          item_count <= count_inc;
          state      <= S_IDLE;
        end
        S_CELL: state <= S_IDLE;
        S_RLOAD: begin
          if (count_zero) begin
            metric_value <= '0;
            no_samples   <= 1'b1;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else if (simple_mode) begin
            state <= S_RDIV;
          end else if (mode == MODE_PREC || mode == MODE_REC || mode == MODE_F1) begin
            state <= S_WALK;
          end else begin
            metric_value <= '0;
            no_samples   <= 1'b0;
            done         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            metric_value <= (mode == MODE_ACC) ? sat16(div_quo) : div_quo[SUM_W-1:0];
            no_samples   <= 1'b0;
            done         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_WALK: begin
          if (phase && (8'(wi) + 8'd1 == eff_n8)) state <= S_WEND;
        end
        S_WEND:  state <= S_CLOAD;
        S_CLOAD: state <= S_CDIV;
        S_CDIV: begin
          if (div_done) begin
            state <= (8'(wc) + 8'd1 == eff_n8) ? S_ALOAD : S_WALK;
          end
        end
        S_ALOAD: state <= S_ADIV;
        S_ADIV: begin
          if (div_done) begin
            metric_value <= sat16(div_quo);
            no_samples   <= 1'b0;
            done         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Transaction capture and report walk datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_lat    <= pred_score;
      t_lat    <= target_score;
      last_lat <= last_in_sample;
      ad_lat   <= ad_in;
      wc       <= '0;
      wi       <= '0;
      phase    <= 1'b0;
      row_sum  <= '0;
      col_sum  <= '0;
      tp       <= '0;
      total    <= '0;
    end
    if (state == S_ACC) begin
      sq        <= SUM_W'(ad_ext[23:0] * ad_ext[23:0]);
      cell_addr <= ram_raddr;
    end
    if (state == S_WALK) begin
      phase <= !phase;
      if (phase) wi <= wi + CPW'(1);
    end
    // Fold in read data in the cycle after its address went out.
    if (pend_v) begin
      if (pend_col) begin
        col_sum <= col_sum + DEN_W'(ram_rdata);
      end else begin
        row_sum <= row_sum + DEN_W'(ram_rdata);
        if (pend_diag) tp <= DEN_W'(ram_rdata);
      end
    end
    pend_col  <= phase;
    pend_diag <= wi == wc;
    if (state == S_CDIV && div_done) begin
      total   <= total + div_quo[TOT_W-1:0];
      wc      <= wc + CPW'(1);
      wi      <= '0;
      phase   <= 1'b0;
      row_sum <= '0;
      col_sum <= '0;
      tp      <= '0;
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && no_samples |-> metric_value == '0)
    else $error("empty report carries a value");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted transaction did not make the block busy");
  a_div_free: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider restarted while running");
  a_cell_rmw: assert property (@(posedge clk) disable iff (rst)
    state == S_CELL |-> $past(state == S_ACC))
    else $error("matrix write without its read");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the metric accumulator: APB setup, scored stream, report checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mma_pkg::*;

  localparam logic CMD_ACCUM  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;
  localparam logic [2:0] MODE_UNDEF_A = 3'd6;
  localparam logic [2:0] MODE_UNDEF_B = 3'd7;
  localparam int CLASSES = MAX_CLASSES_DEF;
  localparam longint unsigned SUM_TOP = (64'd1 << SUM_W) - 1;
  localparam longint unsigned CELL_TOP = (64'd1 << COUNT_WIDTH_DEF) - 1;

  class metric_predictor;
    logic [2:0] mode;
    logic [4:0] classes;
    shortint thresh;
    longint unsigned cells[CLASSES][CLASSES];
    longint unsigned sum;
    longint unsigned count;
    int unsigned pos;
    shortint best_pred, best_tgt;
    int unsigned best_pred_cls, best_tgt_cls;
    logic [SUM_W-1:0] exp_value[$];
    logic exp_empty[$];
    int errors;

    function new();
      mode = MODE_ACC;
      classes = 5'd2;
      thresh = 16'sd2048;
      foreach (cells[r, c]) cells[r][c] = 0;
      sum = 0;
      count = 0;
      pos = 0;
      best_pred = 0;
      best_tgt = 0;
      best_pred_cls = 0;
      best_tgt_cls = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] d);
      case (idx)
        REG_MODE:   mode = d[2:0];
        REG_CLASS:  classes = d[4:0];
        REG_THRESH: thresh = d[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_classes();
      if (classes == 0) return 1;
      if (classes > CLASSES) return CLASSES;
      return classes;
    endfunction

    function void add_sum(longint unsigned v);
      if (v > SUM_TOP - sum) sum = SUM_TOP;
      else sum += v;
    endfunction

    function void bump_count();
      if (count < CELL_TOP) count++;
    endfunction

    function longint unsigned frac(longint unsigned num, longint unsigned den);
      if (den == 0) return 0;
      return (num * 65536) / den;
    endfunction

    function longint unsigned clamp16(longint unsigned v);
      return (v > 65535) ? 65535 : v;
    endfunction

    function longint unsigned class_metric();
      int unsigned n;
      longint unsigned total, tp, row, col;
      n = active_classes();
      total = 0;
      for (int c = 0; c < n; c++) begin
        tp = cells[c][c];
        row = 0;
        col = 0;
        for (int i = 0; i < n; i++) begin
          row += cells[c][i];
          col += cells[i][c];
        end
        if (mode == MODE_PREC) total += frac(tp, col);
        else if (mode == MODE_REC) total += frac(tp, row);
        else total += frac(2 * tp, row + col);
      end
      return clamp16(total / n);
    endfunction

    function void note_item(logic cmd, shortint p, shortint t, logic last);
      longint unsigned v, ad;
      longint d;
      if (cmd == CMD_REPORT) begin
        v = 0;
        if (count != 0) begin
          if (mode == MODE_ACC) v = clamp16(frac(sum, count));
          else if (mode == MODE_PREC || mode == MODE_REC || mode == MODE_F1)
            v = class_metric();
          else if (mode == MODE_MSE || mode == MODE_MAE) v = sum / count;
        end
        exp_value.push_back(v[SUM_W-1:0]);
        exp_empty.push_back(count == 0);
        return;
      end
      if (mode == MODE_ACC) begin
        if ((p >= thresh) == (t >= thresh)) add_sum(1);
        bump_count();
      end else if (mode == MODE_PREC || mode == MODE_REC || mode == MODE_F1) begin
        if (pos == 0) begin
          best_pred = p;
          best_tgt = t;
          best_pred_cls = 0;
          best_tgt_cls = 0;
        end else begin
          if (p > best_pred) begin
            best_pred = p;
            best_pred_cls = pos;
          end
          if (t > best_tgt) begin
            best_tgt = t;
            best_tgt_cls = pos;
          end
        end
        if (last || pos + 1 >= active_classes()) begin
          if (cells[best_tgt_cls % CLASSES][best_pred_cls % CLASSES] < CELL_TOP)
            cells[best_tgt_cls % CLASSES][best_pred_cls % CLASSES]++;
          bump_count();
          pos = 0;
        end else begin
          pos++;
        end
      end else if (mode == MODE_MSE || mode == MODE_MAE) begin
        d = longint'(p) - longint'(t);
        ad = (d < 0) ? -d : d;
        if (mode == MODE_MAE) add_sum(ad);
        else if (ad >= (64'd1 << 24)) sum = SUM_TOP;
        else add_sum(ad * ad);
        bump_count();
      end
    endfunction

    function void check_report(logic [SUM_W-1:0] v, logic ns);
      logic [SUM_W-1:0] ev;
      logic en;
      if (exp_value.size() == 0) begin
        $error("report with none pending: metric_value %0d no_samples %0b", v, ns);
        errors++;
        return;
      end
      ev = exp_value.pop_front();
      en = exp_empty.pop_front();
      if (v !== ev) begin
        $error("metric_value expected %0d actual %0d", ev, v);
        errors++;
      end
      if (ns !== en) begin
        $error("no_samples expected %0b actual %0b", en, ns);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;
  logic start, busy, command, last_in_sample, done, no_samples;
  logic signed [SCORE_WIDTH_DEF-1:0] pred_score, target_score;
  logic [SUM_W-1:0] metric_value;

  metric_predictor pred = new();
  bit calm;

  ml_metric_accumulator uut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && done) pred.check_report(metric_value, no_samples);
  end

  initial begin
    #40ms;
    $display("ml_metric_accumulator: mismatch");
    $finish;
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] d);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = d;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    pred.write_reg(idx, d);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Hold start low through an occasional gap, then leave it high for the next transaction.
  task automatic send(logic cmd, logic [15:0] p, logic [15:0] t, logic last);
    int g;
    if (!calm && $urandom_range(0, 4) == 0) begin
      g = $urandom_range(1, 10);
      @(negedge clk);
      start = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    command = cmd;
    pred_score = p;
    target_score = t;
    last_in_sample = last;
    do @(posedge clk); while (busy);
    pred.note_item(cmd, p, t, last);
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pred.exp_value.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [15:0] any_score();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 3));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic run_phase(int items);
    int n, len, sent;
    logic [2:0] m;
    logic [4:0] k;
    settle();
    m = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    case ($urandom_range(0, 9))
      0: k = 5'd16;
      1: k = 5'($urandom_range(17, 31));
      2: k = 5'd0;
      default: k = 5'($urandom_range(1, 5));
    endcase
    reg_write(REG_MODE, 32'({$urandom(), 3'b000}) | 32'(m));
    reg_write(REG_CLASS, 32'({$urandom(), 5'b00000}) | 32'(k));
    reg_write(REG_THRESH, $urandom());
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 11) == 0) begin
        send(CMD_REPORT, 16'($urandom()), 16'($urandom()), 1'($urandom()));
        sent++;
      end else if ((m == MODE_PREC || m == MODE_REC || m == MODE_F1) &&
                   $urandom_range(0, 9) != 0) begin
        n = pred.active_classes();
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : n;
        for (int i = 0; i < len; i++) begin
          send(CMD_ACCUM, any_score(), any_score(),
               (i == len - 1) ? ((len < n) ? 1'b1 : 1'($urandom())) : 1'b0);
          sent++;
        end
      end else begin
        send(CMD_ACCUM, any_score(), any_score(), 1'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    command = CMD_ACCUM;
    pred_score = '0;
    target_score = '0;
    last_in_sample = 1'b0;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty report, threshold edges, difference extremes, argmax ties.
    send(CMD_REPORT, 16'h0, 16'h0, 1'b0);
    send(CMD_ACCUM, 16'h7fff, 16'h8000, 1'b0);
    send(CMD_ACCUM, 16'h0800, 16'h0800, 1'b0);
    send(CMD_ACCUM, 16'h07ff, 16'h0800, 1'b0);
    send(CMD_REPORT, 16'h0, 16'h0, 1'b0);
    settle();
    reg_write(REG_THRESH, 32'h0000_8000);
    send(CMD_ACCUM, 16'h8000, 16'h7fff, 1'b0);
    send(CMD_REPORT, 16'hffff, 16'hffff, 1'b1);
    settle();
    reg_write(REG_MODE, 32'(MODE_MSE));
    send(CMD_ACCUM, 16'h7fff, 16'h8000, 1'b0);
    send(CMD_ACCUM, 16'h8000, 16'h7fff, 1'b0);
    send(CMD_REPORT, 16'h0, 16'h0, 1'b0);
    settle();
    reg_write(REG_MODE, 32'(MODE_MAE));
    send(CMD_ACCUM, 16'h7fff, 16'h8000, 1'b0);
    send(CMD_REPORT, 16'h0, 16'h0, 1'b0);
    settle();
    reg_write(REG_MODE, 32'(MODE_PREC));
    reg_write(REG_CLASS, 32'd3);
    send(CMD_ACCUM, 16'h0005, 16'h0005, 1'b0);
    send(CMD_ACCUM, 16'h0005, 16'h0005, 1'b0);
    send(CMD_ACCUM, 16'h0005, 16'h0005, 1'b0);
    send(CMD_ACCUM, 16'h8000, 16'h7fff, 1'b0);
    send(CMD_ACCUM, 16'h7fff, 16'h8000, 1'b1);
    send(CMD_REPORT, 16'h0, 16'h0, 1'b0);
    settle();
    // Grow the class count, leave a sample open, then shrink it: the next score closes it at once.
    reg_write(REG_CLASS, 32'd4);
    send(CMD_ACCUM, 16'h0001, 16'h0002, 1'b0);
    send(CMD_ACCUM, 16'h0003, 16'h0001, 1'b0);
    settle();
    reg_write(REG_CLASS, 32'd2);
    send(CMD_ACCUM, 16'h0000, 16'h0000, 1'b0);
    settle();
    reg_write(REG_MODE, 32'(MODE_F1));
    send(CMD_REPORT, 16'h0, 16'h0, 1'b0);
    settle();
    reg_write(REG_MODE, 32'(MODE_REC));
    send(CMD_REPORT, 16'h0, 16'h0, 1'b0);
    settle();
    reg_write(REG_MODE, 32'(MODE_UNDEF_A));
    send(CMD_ACCUM, 16'h1234, 16'h4321, 1'b1);
    send(CMD_REPORT, 16'h0, 16'h0, 1'b0);
    settle();
    reg_write(REG_MODE, 32'(MODE_UNDEF_B));
    send(CMD_REPORT, 16'h0, 16'h0, 1'b0);

    for (int ph = 0; ph < 22; ph++) begin
      if (ph >= 19) calm = 1'b1;
      run_phase(64);
    end

    settle();
    if (pred.errors == 0 && pred.exp_value.size() == 0) begin
      $display("ml_metric_accumulator: match");
    end else begin
      $display("ml_metric_accumulator: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mma_pkg.sv
sv/mma_ram.sv
sv/mma_div.sv
sv/ml_metric_accumulator.sv
bench/testbench.sv
